// ===== sv/fspa_pkg.sv =====
`default_nettype none
package fspa_pkg;

  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 11;
  localparam int OSIZE_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ST_W      = 3;
  localparam int SLOT_W    = 17;
  localparam int SPAN_W    = SLOT_W + CNT_W;
  localparam int DIV_STEPS = 6;
  localparam int QUO_W     = 2 * DIV_STEPS;
  localparam int DIV_W     = SLOT_W + 2 + 2 * (DIV_STEPS - 1);
  localparam int RECIP_SH  = 21;

  localparam logic [CNT_W-1:0]   CAP_RESET   = 11'd1024;
  localparam logic [OSIZE_W-1:0] OSIZE_RESET = 16'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 2'd0,
    REG_BASE     = 2'd1,
    REG_OSIZE    = 2'd2,
    REG_CAPACITY = 2'd3
  } cfg_reg_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 3'd0,
    ST_NOT_ENABLED  = 3'd1,
    ST_EMPTY        = 3'd2,
    ST_NULL_ADDR    = 3'd3,
    ST_OUT_OF_RANGE = 3'd4,
    ST_MISALIGNED   = 3'd5,
    ST_ALREADY_FREE = 3'd6
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    CL_DISABLED = 3'd0,
    CL_ALLOC    = 3'd1,
    CL_NULL     = 3'd2,
    CL_RANGE    = 3'd3,
    CL_FREE     = 3'd4
  } req_class_t;

  typedef struct packed {
    req_class_t        cls;
    logic [SPAN_W-1:0] off;
  } q_entry_t;

  typedef struct packed {
    logic              enable;
    logic              busy;
    logic              load;
    logic [ADDR_W-1:0] base;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W+1:0] slot3;
    logic [CNT_W-1:0]  cap;
    logic [SPAN_W-1:0] span;
  } pool_cfg_t;

endpackage
`default_nettype wire

// ===== sv/fspa_req_if.sv =====
`default_nettype none
interface fspa_req_if;
  import fspa_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output op, output address, input ready);
  modport sink (input valid, input op, input address, output ready);
endinterface
`default_nettype wire

// ===== sv/fspa_rsp_if.sv =====
`default_nettype none
interface fspa_rsp_if;
  import fspa_pkg::*;

  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [ADDR_W-1:0] slot_address;
  logic [CNT_W-1:0]  free_slots;
  logic [CNT_W-1:0]  peak_used;
  logic [ADDR_W-1:0] failed_allocs;

  modport source (output valid, output status, output slot_address, output free_slots,
                  output peak_used, output failed_allocs, input ready);
  modport sink (input valid, input status, input slot_address, input free_slots,
                input peak_used, input failed_allocs, output ready);
endinterface
`default_nettype wire

// ===== sv/fspa_cfg.sv =====
`default_nettype none
module fspa_cfg #(
  parameter int MAX_SLOTS = 1024,
  parameter int PTR_BYTES = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fspa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fspa_pkg::ADDR_W-1:0]    cfg_data,
  output fspa_pkg::pool_cfg_t            pool
);
  import fspa_pkg::*;

  localparam int Recip    = ((1 << RECIP_SH) + PTR_BYTES - 1) / PTR_BYTES;
  localparam int RECIP_W  = $clog2(Recip + 1);
  localparam int MIN_SLOT = ((PTR_BYTES + 4 + PTR_BYTES - 1) / PTR_BYTES) * PTR_BYTES;
  localparam int PROD_W   = SLOT_W + RECIP_W;

  typedef enum logic [1:0] {
    LD_IDLE,
    LD_SPAN,
    LD_SLOT,
    LD_QUOT
  } load_step_t;

  load_step_t          ld_step;
  logic                enable;
  logic [ADDR_W-1:0]   base_address;
  logic [OSIZE_W-1:0]  object_size;
  logic [CNT_W-1:0]    capacity;
  logic [OSIZE_W-1:0]  ld_size;
  logic [SLOT_W-1:0]   ld_quot;
  logic [ADDR_W-1:0]   eff_base;
  logic [SLOT_W-1:0]   eff_slot;
  logic [SLOT_W+1:0]   eff_slot3;
  logic [CNT_W-1:0]    eff_cap;
  logic [SPAN_W-1:0]   eff_span;

  cfg_reg_t            wr_reg;
  logic                start;
  logic [CNT_W-1:0]    cap_sat;
  logic [SLOT_W-1:0]   ld_sum;
  logic [PROD_W-1:0]   ld_prod;
  logic [SLOT_W-1:0]   ld_round;

  assign wr_reg   = cfg_reg_t'(cfg_index);
  assign start    = cfg_we && (wr_reg == REG_ENABLE) && cfg_data[0] && !enable;
  assign cap_sat  = (32'(capacity) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : capacity;
  assign ld_sum   = SLOT_W'(ld_size) + SLOT_W'(PTR_BYTES - 1);
  assign ld_prod  = PROD_W'(ld_sum) * PROD_W'(Recip);
  assign ld_round = SLOT_W'(ld_quot * SLOT_W'(PTR_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      base_address <= '0;
      object_size  <= OSIZE_RESET;
      capacity     <= CAP_RESET;
      ld_step      <= LD_IDLE;
      eff_cap      <= '0;
    end else begin
      if (cfg_we) begin
        case (wr_reg)
          REG_ENABLE:   enable <= cfg_data[0];
          REG_BASE:     base_address <= cfg_data;
          REG_OSIZE:    object_size <= cfg_data[OSIZE_W-1:0];
          REG_CAPACITY: capacity <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      case (ld_step)
        LD_QUOT: begin
          ld_quot <= SLOT_W'(ld_prod >> RECIP_SH);
          ld_step <= LD_SLOT;
        end
        LD_SLOT: begin
          eff_slot <= (ld_round < SLOT_W'(MIN_SLOT)) ? SLOT_W'(MIN_SLOT) : ld_round;
          ld_step  <= LD_SPAN;
        end
        LD_SPAN: begin
          eff_slot3 <= (SLOT_W + 2)'(eff_slot) + {1'b0, eff_slot, 1'b0};
          eff_span  <= SPAN_W'(eff_slot) * SPAN_W'(eff_cap);
          ld_step   <= LD_IDLE;
        end
        default: ;
      endcase
      if (start) begin
        eff_base <= base_address;
        eff_cap  <= cap_sat;
        ld_size  <= object_size;
        ld_step  <= LD_QUOT;
      end
    end
  end

  always_comb begin
    pool.enable = enable;
    pool.busy   = (ld_step != LD_IDLE);
    pool.load   = (ld_step == LD_QUOT);
    pool.base   = eff_base;
    pool.slot   = eff_slot;
    pool.slot3  = eff_slot3;
    pool.cap    = eff_cap;
    pool.span   = eff_span;
  end

endmodule
`default_nettype wire

// ===== sv/fspa_front.sv =====
`default_nettype none
module fspa_front (
  fspa_req_if.sink            req,
  input  fspa_pkg::pool_cfg_t pool,
  input  logic                q_full,
  output logic                q_push,
  output fspa_pkg::q_entry_t  q_data
);
  import fspa_pkg::*;

  logic [ADDR_W-1:0] off;

  assign off       = req.address - pool.base;
  assign req.ready = !q_full && !pool.busy;
  assign q_push    = req.valid && req.ready;

  always_comb begin
    q_data.off = off[SPAN_W-1:0];
    if (!pool.enable) begin
      q_data.cls = CL_DISABLED;
    end else if (op_t'(req.op) == OP_ALLOC) begin
      q_data.cls = CL_ALLOC;
    end else if (req.address == '0) begin
      q_data.cls = CL_NULL;
    end else if (off >= ADDR_W'(pool.span)) begin
      q_data.cls = CL_RANGE;
    end else begin
      q_data.cls = CL_FREE;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fspa_queue.sv =====
`default_nettype none
module fspa_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  fspa_pkg::q_entry_t push_data,
  input  logic               pop,
  output fspa_pkg::q_entry_t pop_data,
  output logic               full,
  output logic               empty
);
  import fspa_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_QW = $clog2(DEPTH + 1);

  q_entry_t           entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_QW-1:0]  count;

  assign full     = (count == CNT_QW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_QW'(push) - CNT_QW'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== sv/fspa_back.sv =====
`default_nettype none
module fspa_back #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  fspa_pkg::pool_cfg_t pool,
  input  logic                q_empty,
  input  fspa_pkg::q_entry_t  q_data,
  output logic                q_pop,
  fspa_rsp_if.source          rsp
);
  import fspa_pkg::*;

  localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int DCNT_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_A_MUL,
    S_A_ADD,
    S_DIV,
    S_F_SET,
    S_F_RD,
    S_F_CHK,
    S_EMIT
  } state_t;

  logic [IDX_W-1:0]  next_link [MAX_SLOTS];
  logic              mark_mem [MAX_SLOTS];

  state_t            state;
  logic [IDX_W-1:0]  list_head;
  logic [CNT_W-1:0]  untouched_top;
  logic [CNT_W-1:0]  free_total;
  logic [CNT_W-1:0]  peak_count;
  logic [ADDR_W-1:0] fail_count;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] prod;
  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [SPAN_W-1:0] rem;
  logic [DIV_W-1:0]  dv1;
  logic [DIV_W-1:0]  dv2;
  logic [DIV_W-1:0]  dv3;
  logic [QUO_W-1:0]  quot;
  logic [DCNT_W-1:0] div_cnt;
  logic [IDX_W-1:0]  link_rd;
  logic              mark_rd;

  logic              mark_now;
  logic              link_we;
  logic              mark_we;
  logic              mark_wdata;
  logic [CNT_W-1:0]  used;
  logic [1:0]        digit;
  logic [SPAN_W-1:0] rem_nx;
  logic [DIV_W-1:0]  rem_ext;

  assign q_pop      = (state == S_IDLE) && !q_empty;
  assign mark_now   = (32'(idx) < 32'(untouched_top)) || mark_rd;
  assign link_we    = (state == S_F_CHK) && !mark_now;
  assign mark_we    = (state == S_A_MUL) || link_we;
  assign mark_wdata = (state != S_A_MUL);
  assign used       = pool.cap - free_total;
  assign rem_ext    = DIV_W'(rem);

  // one radix-4 restoring step
  always_comb begin
    digit  = 2'd0;
    rem_nx = rem;
    if (rem_ext >= dv3) begin
      digit  = 2'd3;
      rem_nx = SPAN_W'(rem_ext - dv3);
    end else if (rem_ext >= dv2) begin
      digit  = 2'd2;
      rem_nx = SPAN_W'(rem_ext - dv2);
    end else if (rem_ext >= dv1) begin
      digit  = 2'd1;
      rem_nx = SPAN_W'(rem_ext - dv1);
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      next_link[idx] <= list_head;
    end
    link_rd <= next_link[list_head];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[idx] <= mark_wdata;
    end
    mark_rd <= mark_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      list_head     <= '0;
      untouched_top <= '0;
      free_total    <= '0;
      peak_count    <= '0;
      fail_count    <= '0;
      rsp.valid     <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (pool.load) begin
        list_head     <= '0;
        untouched_top <= pool.cap;
        free_total    <= pool.cap;
        peak_count    <= '0;
        fail_count    <= '0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            res_addr <= '0;
            case (q_data.cls)
              CL_ALLOC: begin
                if (free_total > untouched_top) begin
                  idx   <= list_head;
                  state <= S_POP;
                end else if (untouched_top != '0) begin
                  untouched_top <= untouched_top - 1'b1;
                  idx           <= IDX_W'(untouched_top - 1'b1);
                  state         <= S_A_MUL;
                end else begin
                  res_status <= ST_EMPTY;
                  fail_count <= fail_count + 1'b1;
                  state      <= S_EMIT;
                end
              end
              CL_NULL: begin
                res_status <= ST_NULL_ADDR;
                state      <= S_EMIT;
              end
              CL_RANGE: begin
                res_status <= ST_OUT_OF_RANGE;
                state      <= S_EMIT;
              end
              CL_FREE: begin
                rem     <= q_data.off;
                dv1     <= DIV_W'(pool.slot) << (2 * (DIV_STEPS - 1));
                dv2     <= DIV_W'(pool.slot) << (2 * DIV_STEPS - 1);
                dv3     <= DIV_W'(pool.slot3) << (2 * (DIV_STEPS - 1));
                quot    <= '0;
                div_cnt <= DCNT_W'(DIV_STEPS - 1);
                state   <= S_DIV;
              end
              default: begin
                res_status <= ST_NOT_ENABLED;
                state      <= S_EMIT;
              end
            endcase
          end
        end
        S_POP: begin
          list_head <= link_rd;
          state     <= S_A_MUL;
        end
        S_A_MUL: begin
          free_total <= free_total - 1'b1;
          prod       <= ADDR_W'(idx) * ADDR_W'(pool.slot);
          state      <= S_A_ADD;
        end
        S_A_ADD: begin
          res_addr   <= pool.base + prod;
          res_status <= ST_OK;
          if (used > peak_count) begin
            peak_count <= used;
          end
          state <= S_EMIT;
        end
        S_DIV: begin
          rem  <= rem_nx;
          quot <= {quot[QUO_W-3:0], digit};
          dv1  <= dv1 >> 2;
          dv2  <= dv2 >> 2;
          dv3  <= dv3 >> 2;
          if (div_cnt == '0) begin
            state <= S_F_SET;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_F_SET: begin
          if (rem != '0) begin
            res_status <= ST_MISALIGNED;
            state      <= S_EMIT;
          end else begin
            idx   <= IDX_W'(quot);
            state <= S_F_RD;
          end
        end
        S_F_RD: begin
          state <= S_F_CHK;
        end
        S_F_CHK: begin
          if (mark_now) begin
            res_status <= ST_ALREADY_FREE;
          end else begin
            list_head  <= idx;
            res_status <= ST_OK;
            if (free_total < pool.cap) begin
              free_total <= free_total + 1'b1;
            end
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid         <= 1'b1;
            rsp.status        <= res_status;
            rsp.slot_address  <= res_addr;
            rsp.free_slots    <= free_total;
            rsp.peak_used     <= peak_count;
            rsp.failed_allocs <= fail_count;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/fixed_slot_pool_allocator.sv =====
// paths: a request word goes into the request queue first; an allocate from untouched
// slots then runs the multiply and add states, one from the pushed free list first pops the list head,
// a free runs 6 radix-4 divider steps and then the index checks, and a rejected word goes
// straight to emit; plus the output register. One word per back-end pass; the free path divider sets the worst case
// a 0->1 enable write loads the pool and holds off requests during its quotient, slot and span steps
// synchronous reset: pool disabled, counts zero, config registers at their defaults
`default_nettype none
module fixed_slot_pool_allocator #(
  parameter int MAX_SLOTS = 1024,
  parameter int PTR_BYTES = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fspa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fspa_pkg::ADDR_W-1:0]    cfg_data,
  fspa_req_if.sink                       req,
  fspa_rsp_if.source                     rsp
);
  import fspa_pkg::*;

  pool_cfg_t pool;
  q_entry_t  q_in;
  q_entry_t  q_out;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  fspa_cfg #(
    .MAX_SLOTS (MAX_SLOTS),
    .PTR_BYTES (PTR_BYTES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pool      (pool)
  );

  fspa_front u_front (
    .req    (req),
    .pool   (pool),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  fspa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  fspa_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .pool    (pool),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue pushed while full");

  a_load_blocks: assert property (@(posedge clk) disable iff (rst) pool.busy |-> !req.ready)
    else $error("request taken during pool load");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !pool.busy) |-> (rsp.free_slots <= pool.cap))
    else $error("free count above capacity");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.slot_address == '0))
    else $error("address given with a failed word");

endmodule
`default_nettype wire
